// File: rtl/core/wpf_pkg.sv
// ----------------------------------------------------------------------------
// Waypoint path follower package
// Shared constants, codes, command and status types, and the saturation
// helper used by the datapath.
// ----------------------------------------------------------------------------
package wpf_pkg;

   localparam int MAX_WAYPOINTS = 16;
   localparam int IDX_W         = $clog2(MAX_WAYPOINTS);
   localparam int COUNT_W       = 5;
   localparam int CSR_IDX_W     = 3;
   localparam int COORD_W       = 32;
   localparam int DIFF_W        = COORD_W + 1;
   localparam int SUM_W         = 2 * DIFF_W;
   localparam int ROOT_W        = DIFF_W;
   localparam int SREM_W        = ROOT_W + 2;
   localparam int SPEED_W       = 24;
   localparam int TIME_W        = 16;
   localparam int NUM_W         = SPEED_W + TIME_W;
   localparam int PROG_W        = 18;
   localparam int PROG_FRAC     = 16;
   localparam int PROD_W        = DIFF_W + PROG_W + 1;
   localparam int MV_W          = COORD_W + 5;
   localparam int SAT_W         = MV_W + 1;
   localparam int SQRT_STEPS    = SUM_W / 2;
   localparam int DIV_STEPS     = NUM_W;
   localparam int STEP_W        = $clog2(DIV_STEPS + 1);
   localparam int AXES          = 3;

   localparam logic [PROG_W-1:0] PROG_ONE = PROG_W'(1) << PROG_FRAC;
   localparam logic [PROG_W-1:0] PROG_MAX = {PROG_W{1'b1}};

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SPEED    = 3'd0,
      CSR_COUNT    = 3'd1,
      CSR_ORIGIN_X = 3'd2,
      CSR_ORIGIN_Y = 3'd3,
      CSR_ORIGIN_Z = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } point_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_LOAD,
      OP_RD_FROM,
      OP_RD_TO,
      OP_LATCH,
      OP_SQ,
      OP_SQRT_INIT,
      OP_SQRT,
      OP_DIV_INIT,
      OP_DIV,
      OP_UPDATE,
      OP_MUL,
      OP_FINISH,
      OP_EMPTY
   } dp_op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOAD,
      S_RD_FROM,
      S_RD_TO,
      S_LATCH,
      S_SQ,
      S_SQRT_INIT,
      S_SQRT,
      S_DIV_INIT,
      S_DIV,
      S_UPDATE,
      S_MUL,
      S_FINISH,
      S_EMPTY
   } state_type;

   typedef struct packed {
      logic      ready;
      dp_op_type op;
      logic [1:0] axis;
   } cmd_type;

   typedef struct packed {
      logic req_valid;
      logic req_tick;
      logic count_zero;
      logic dist_zero;
      logic out_free;
   } stat_type;

   function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
      logic signed [SAT_W-1:0] hi;
      logic signed [SAT_W-1:0] lo;
      hi = SAT_W'(signed'({1'b0, {(COORD_W-1){1'b1}}}));
      lo = SAT_W'(signed'({1'b1, {(COORD_W-1){1'b0}}}));
      if (v > hi) begin
         return hi[COORD_W-1:0];
      end else if (v < lo) begin
         return lo[COORD_W-1:0];
      end
      return v[COORD_W-1:0];
   endfunction

endpackage

// File: rtl/core/wpf_if.sv
// ----------------------------------------------------------------------------
// Waypoint path follower channels
// Valid/ready channels for requests, responses and register writes.
// ----------------------------------------------------------------------------
interface wpf_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [3:0]  slot;
   logic signed [31:0] offset_x;
   logic signed [31:0] offset_y;
   logic signed [31:0] offset_z;
   logic signed [31:0] position_x;
   logic signed [31:0] position_y;
   logic signed [31:0] position_z;
   logic [15:0] elapsed;

   modport source (output valid, cmd, slot, offset_x, offset_y, offset_z,
                   position_x, position_y, position_z, elapsed, input ready);
   modport sink (input valid, cmd, slot, offset_x, offset_y, offset_z,
                 position_x, position_y, position_z, elapsed, output ready);
endinterface

interface wpf_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [31:0] move_x;
   logic signed [31:0] move_y;
   logic signed [31:0] move_z;
   logic [3:0]  segment_start;
   logic        reached;
   logic        idle;

   modport source (output valid, move_x, move_y, move_z, segment_start, reached, idle,
                   input ready);
   modport sink (input valid, move_x, move_y, move_z, segment_start, reached, idle,
                 output ready);
endinterface

interface wpf_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/wpf_ctrl.sv
// ----------------------------------------------------------------------------
// Waypoint path follower controller
// Sequences load and tick requests through the datapath step by step.
// ----------------------------------------------------------------------------
module wpf_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  wpf_pkg::stat_type stat,
   output wpf_pkg::cmd_type  cmd
);
   import wpf_pkg::*;

   state_type            state_ff, state_in;
   logic [STEP_W-1:0]    step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.ready = 1'b0;
      cmd.op    = OP_NONE;
      cmd.axis  = step_ff[1:0];
      case (state_ff)
         S_IDLE: begin
            cmd.ready = 1'b1;
            if (stat.req_valid) begin
               cmd.op = OP_CAPTURE;
               if (!stat.req_tick) begin
                  state_in = S_LOAD;
               end else if (stat.count_zero) begin
                  state_in = S_EMPTY;
               end else begin
                  state_in = S_RD_FROM;
               end
            end
         end
         S_LOAD: begin
            cmd.op   = OP_LOAD;
            state_in = S_IDLE;
         end
         S_RD_FROM: begin
            cmd.op   = OP_RD_FROM;
            state_in = S_RD_TO;
         end
         S_RD_TO: begin
            cmd.op   = OP_RD_TO;
            state_in = S_LATCH;
         end
         S_LATCH: begin
            cmd.op   = OP_LATCH;
            state_in = S_SQ;
         end
         S_SQ: begin
            cmd.op = OP_SQ;
            if (step_ff == STEP_W'(AXES - 1)) begin
               state_in = S_SQRT_INIT;
            end
         end
         S_SQRT_INIT: begin
            cmd.op   = OP_SQRT_INIT;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd.op = OP_SQRT;
            if (step_ff == STEP_W'(SQRT_STEPS - 1)) begin
               state_in = S_DIV_INIT;
            end
         end
         S_DIV_INIT: begin
            if (stat.dist_zero) begin
               state_in = S_FINISH;
            end else begin
               cmd.op   = OP_DIV_INIT;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.op = OP_DIV;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            cmd.op   = OP_UPDATE;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.op = OP_MUL;
            if (step_ff == STEP_W'(AXES - 1)) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.op   = OP_FINISH;
               state_in = S_IDLE;
            end
         end
         S_EMPTY: begin
            if (stat.out_free) begin
               cmd.op   = OP_EMPTY;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      step_in = (state_in != state_ff) ? '0 : step_ff + STEP_W'(1);
   end

endmodule

// File: rtl/core/wpf_dp.sv
// ----------------------------------------------------------------------------
// Waypoint path follower datapath
// Waypoint memory, registers, squared length, bit-serial square root and
// divider, interpolation multiplier and the response register.
// ----------------------------------------------------------------------------
module wpf_dp (
   input  logic              clock,
   input  logic              reset,
   wpf_req_if.sink           req,
   wpf_rsp_if.source         rsp,
   wpf_csr_if.sink           csr,
   input  wpf_pkg::cmd_type  cmd,
   output wpf_pkg::stat_type stat
);
   import wpf_pkg::*;

   point_type                 mem_ff [MAX_WAYPOINTS];
   point_type                 rd_data_ff;
   logic [IDX_W-1:0]          rd_addr;

   logic [IDX_W-1:0]          slot_ff, slot_in;
   point_type                 off_ff, off_in;
   point_type                 pos_ff, pos_in;
   logic [TIME_W-1:0]         dt_ff, dt_in;

   logic [SPEED_W-1:0]        speed_ff, speed_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   point_type                 origin_ff, origin_in;

   logic [IDX_W-1:0]          start_ff, start_in;
   logic [PROG_W-1:0]         progress_ff, progress_in;

   point_type                 from_ff, from_in;
   logic signed [DIFF_W-1:0]  diff_ff [AXES];
   logic signed [DIFF_W-1:0]  diff_in [AXES];
   logic [SUM_W-1:0]          sum_ff, sum_in;
   logic [SUM_W-1:0]          rad_ff, rad_in;
   logic [ROOT_W-1:0]         root_ff, root_in;
   logic [SREM_W-1:0]         srem_ff, srem_in;
   logic [NUM_W-1:0]          num_ff, num_in;
   logic [ROOT_W-1:0]         drem_ff, drem_in;
   logic signed [MV_W-1:0]    mv_ff [AXES];
   logic signed [MV_W-1:0]    mv_in [AXES];

   logic                      rsp_valid_ff, rsp_valid_in;
   point_type                 move_ff, move_in;
   logic [IDX_W-1:0]          seg_ff, seg_in;
   logic                      reached_ff, reached_in;
   logic                      idle_ff, idle_in;

   logic [COUNT_W-1:0]        count_use;
   logic [COUNT_W-1:0]        start_next;
   logic [IDX_W-1:0]          to_idx;
   point_type                 load_pt;
   logic signed [DIFF_W-1:0]  sel_diff;
   logic [DIFF_W-1:0]         mag;
   logic [SUM_W-1:0]          sq;
   logic [SREM_W+1:0]         srem_cat;
   logic [SREM_W+1:0]         strial;
   logic [ROOT_W:0]           drem_cat;
   logic signed [PROD_W-1:0]  prod;
   logic signed [MV_W-1:0]    interp;
   logic [PROG_W:0]           prog_sum;
   logic                      reached_now;
   point_type                 end_pt;

   assign count_use  = (count_ff > COUNT_W'(MAX_WAYPOINTS)) ? COUNT_W'(MAX_WAYPOINTS)
                                                              : count_ff;
   assign start_next = COUNT_W'(start_ff) + COUNT_W'(1);
   assign to_idx     = (start_next < count_use) ? start_next[IDX_W-1:0] : '0;
   assign rd_addr    = (cmd.op == OP_RD_FROM) ? start_ff : to_idx;

   assign load_pt.x = sat32(SAT_W'(off_ff.x) + SAT_W'(origin_ff.x));
   assign load_pt.y = sat32(SAT_W'(off_ff.y) + SAT_W'(origin_ff.y));
   assign load_pt.z = sat32(SAT_W'(off_ff.z) + SAT_W'(origin_ff.z));

   assign sel_diff = diff_ff[cmd.axis];
   assign mag      = sel_diff[DIFF_W-1] ? DIFF_W'(-sel_diff) : DIFF_W'(sel_diff);
   assign sq       = mag * mag;
   assign srem_cat = {srem_ff, rad_ff[SUM_W-1 -: 2]};
   assign strial   = (SREM_W+2)'({root_ff, 2'b01});
   assign drem_cat = {drem_ff, num_ff[NUM_W-1]};
   assign prod     = sel_diff * signed'({1'b0, progress_ff});
   assign interp   = MV_W'(prod >>> PROG_FRAC);
   assign prog_sum = (PROG_W+1)'(progress_ff) + (PROG_W+1)'(num_ff[PROG_W-1:0]);
   assign reached_now = (root_ff == '0) || (progress_ff >= PROG_ONE);

   assign end_pt.x = sat32((root_ff == '0) ? SAT_W'(from_ff.x) - SAT_W'(pos_ff.x)
                                            : SAT_W'(mv_ff[0]) - SAT_W'(pos_ff.x));
   assign end_pt.y = sat32((root_ff == '0) ? SAT_W'(from_ff.y) - SAT_W'(pos_ff.y)
                                            : SAT_W'(mv_ff[1]) - SAT_W'(pos_ff.y));
   assign end_pt.z = sat32((root_ff == '0) ? SAT_W'(from_ff.z) - SAT_W'(pos_ff.z)
                                            : SAT_W'(mv_ff[2]) - SAT_W'(pos_ff.z));

   assign req.ready = cmd.ready;
   assign csr.ready = 1'b1;

   assign stat.req_valid  = req.valid;
   assign stat.req_tick   = (req.cmd == CMD_TICK);
   assign stat.count_zero = (count_ff == '0);
   assign stat.dist_zero  = (root_ff == '0);
   assign stat.out_free   = !rsp_valid_ff;

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.move_x        = move_ff.x;
   assign rsp.move_y        = move_ff.y;
   assign rsp.move_z        = move_ff.z;
   assign rsp.segment_start = seg_ff;
   assign rsp.reached       = reached_ff;
   assign rsp.idle          = idle_ff;

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) begin
         mem_ff[slot_ff] <= load_pt;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   always_comb begin
      slot_in     = slot_ff;
      off_in      = off_ff;
      pos_in      = pos_ff;
      dt_in       = dt_ff;
      speed_in    = speed_ff;
      count_in    = count_ff;
      origin_in   = origin_ff;
      start_in    = start_ff;
      progress_in = progress_ff;
      from_in     = from_ff;
      diff_in     = diff_ff;
      sum_in      = sum_ff;
      rad_in      = rad_ff;
      root_in     = root_ff;
      srem_in     = srem_ff;
      num_in      = num_ff;
      drem_in     = drem_ff;
      mv_in       = mv_ff;
      move_in     = move_ff;
      seg_in      = seg_ff;
      reached_in  = reached_ff;
      idle_in     = idle_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;

      if (csr.valid) begin
         case (csr_index_type'(csr.index))
            CSR_SPEED:    speed_in    = csr.data[SPEED_W-1:0];
            CSR_COUNT:    count_in    = csr.data[COUNT_W-1:0];
            CSR_ORIGIN_X: origin_in.x = csr.data;
            CSR_ORIGIN_Y: origin_in.y = csr.data;
            CSR_ORIGIN_Z: origin_in.z = csr.data;
            default: ;
         endcase
      end

      case (cmd.op)
         OP_CAPTURE: begin
            slot_in  = req.slot;
            off_in   = '{req.offset_x, req.offset_y, req.offset_z};
            pos_in   = '{req.position_x, req.position_y, req.position_z};
            dt_in    = req.elapsed;
            if ((req.cmd == CMD_TICK) && (count_use != '0)
                && (COUNT_W'(start_ff) >= count_use)) begin
               start_in = '0;
            end
         end
         OP_RD_TO: begin
            from_in = rd_data_ff;
            sum_in  = '0;
         end
         OP_LATCH: begin
            diff_in[0] = DIFF_W'(rd_data_ff.x) - DIFF_W'(from_ff.x);
            diff_in[1] = DIFF_W'(rd_data_ff.y) - DIFF_W'(from_ff.y);
            diff_in[2] = DIFF_W'(rd_data_ff.z) - DIFF_W'(from_ff.z);
         end
         OP_SQ: begin
            sum_in = sum_ff + sq;
         end
         OP_SQRT_INIT: begin
            rad_in  = sum_ff;
            root_in = '0;
            srem_in = '0;
         end
         OP_SQRT: begin
            rad_in = {rad_ff[SUM_W-3:0], 2'b00};
            if (srem_cat >= strial) begin
               srem_in = SREM_W'(srem_cat - strial);
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               srem_in = SREM_W'(srem_cat);
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
         end
         OP_DIV_INIT: begin
            num_in  = NUM_W'(dt_ff) * NUM_W'(speed_ff);
            drem_in = '0;
         end
         OP_DIV: begin
            if (drem_cat >= (ROOT_W+1)'(root_ff)) begin
               drem_in = ROOT_W'(drem_cat - (ROOT_W+1)'(root_ff));
               num_in  = {num_ff[NUM_W-2:0], 1'b1};
            end else begin
               drem_in = ROOT_W'(drem_cat);
               num_in  = {num_ff[NUM_W-2:0], 1'b0};
            end
         end
         OP_UPDATE: begin
            if ((num_ff[NUM_W-1:PROG_W] != '0) || prog_sum[PROG_W]) begin
               progress_in = PROG_MAX;
            end else begin
               progress_in = prog_sum[PROG_W-1:0];
            end
         end
         OP_MUL: begin
            case (cmd.axis)
               2'd0:    mv_in[0] = MV_W'(from_ff.x) + interp;
               2'd1:    mv_in[1] = MV_W'(from_ff.y) + interp;
               default: mv_in[2] = MV_W'(from_ff.z) + interp;
            endcase
         end
         OP_FINISH: begin
            move_in      = end_pt;
            reached_in   = reached_now;
            idle_in      = 1'b0;
            rsp_valid_in = 1'b1;
            if (reached_now) begin
               progress_in = '0;
               start_in    = to_idx;
               seg_in      = to_idx;
            end else begin
               seg_in      = start_ff;
            end
         end
         OP_EMPTY: begin
            move_in      = '0;
            reached_in   = 1'b0;
            idle_in      = 1'b1;
            seg_in       = start_ff;
            rsp_valid_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff     <= '0;
         count_ff     <= '0;
         origin_ff    <= '0;
         start_ff     <= '0;
         progress_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         speed_ff     <= speed_in;
         count_ff     <= count_in;
         origin_ff    <= origin_in;
         start_ff     <= start_in;
         progress_ff  <= progress_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      slot_ff    <= slot_in;
      off_ff     <= off_in;
      pos_ff     <= pos_in;
      dt_ff      <= dt_in;
      from_ff    <= from_in;
      diff_ff    <= diff_in;
      sum_ff     <= sum_in;
      rad_ff     <= rad_in;
      root_ff    <= root_in;
      srem_ff    <= srem_in;
      num_ff     <= num_in;
      drem_ff    <= drem_in;
      mv_ff      <= mv_in;
      move_ff    <= move_in;
      seg_ff     <= seg_in;
      reached_ff <= reached_in;
      idle_ff    <= idle_in;
   end

endmodule

// File: rtl/core/waypoint_path_follower.sv
// Load request: captured, then written to the waypoint memory in S_LOAD; the next
// request is taken back in S_IDLE. Tick request: reads, latch, squares, the 33-step
// square root, the 40-step divider, update and multiply; a zero-length segment skips
// the divider, update and multiply; no waypoints gives an idle response. One request
// at a time; a response still waiting holds the next tick in its last step.
// Reset (synchronous): registers, start index and progress cleared.
// ----------------------------------------------------------------------------
// Waypoint path follower
// Moves a point around a closed loop of waypoints at constant speed.
// ----------------------------------------------------------------------------
module waypoint_path_follower (
   input  logic      clock,
   input  logic      reset,
   wpf_req_if.sink   req_bus,
   wpf_rsp_if.source rsp_bus,
   wpf_csr_if.sink   csr_bus
);
   import wpf_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   wpf_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   wpf_dp u_dp (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .csr   (csr_bus),
      .cmd   (cmd),
      .stat  (stat)
   );

endmodule

// File: rtl/core/wpf_checker.sv
// ----------------------------------------------------------------------------
// Waypoint path follower checker
// Port-level properties of the response channel.
// ----------------------------------------------------------------------------
module wpf_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_move_x,
   input logic [31:0] rsp_move_y,
   input logic [31:0] rsp_move_z,
   input logic        rsp_reached,
   input logic        rsp_idle
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_move_x) && $stable(rsp_idle))
      else $error("response changed while stalled");

   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_idle |-> rsp_move_x == '0 && rsp_move_y == '0
                                && rsp_move_z == '0)
      else $error("idle response with non-zero move");

   a_idle_reach: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_idle |-> !rsp_reached)
      else $error("idle response flags reached");

endmodule

bind waypoint_path_follower wpf_checker u_wpf_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_move_x  (rsp_bus.move_x),
   .rsp_move_y  (rsp_bus.move_y),
   .rsp_move_z  (rsp_bus.move_z),
   .rsp_reached (rsp_bus.reached),
   .rsp_idle    (rsp_bus.idle)
);

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// Waypoint path follower testbench
// Loads a loop of waypoints and sends ticks through the request channel, with
// register changes between phases. A predictor tracks the table, the start
// index and progress, and each response is checked against the oldest
// expected motion. Both channels idle at random, and one long response
// hold-off makes the block stall its request channel.
// ----------------------------------------------------------------------------
module tb_top;
   import wpf_pkg::*;

   localparam int LIMIT     = 600000;
   localparam int SETTLE    = 100;
   localparam int PHASE_LEN = 130;

   typedef struct {
      logic               cmd;
      logic [3:0]         slot;
      logic signed [31:0] off_x, off_y, off_z;
      logic signed [31:0] pos_x, pos_y, pos_z;
      logic [15:0]        dt;
   } request_type;

   typedef struct {
      logic signed [31:0] mx, my, mz;
      logic [3:0]         seg;
      logic               hit;
      logic               idle;
   } motion_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic sink_ready = 1'b0;
   logic hold_off = 1'b0;
   logic busy_sink = 1'b0;
   int   cycles = 0;
   int   errors = 0;
   int   n_ticks = 0, n_loads = 0, n_hits = 0, n_idle = 0;

   wpf_req_if req_if ();
   wpf_rsp_if rsp_if ();
   wpf_csr_if csr_if ();

   waypoint_path_follower DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if.sink),
      .rsp_bus (rsp_if.source),
      .csr_bus (csr_if.sink)
   );

   assign rsp_if.ready = sink_ready && !hold_off;

   // predictor state
   longint      waypoints [MAX_WAYPOINTS][AXES];
   longint      origin [AXES];
   logic [23:0] speed_reg;
   logic [4:0]  count_reg;
   logic [3:0]  start_idx;
   logic [17:0] prog;
   motion_type  expected_motion [$];

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("waypoint_path_follower regression: fail");
         $finish;
      end
   end

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch at cycle %0d: %s got %0d want %0d", cycles, what, got, want);
      errors++;
   endtask

   task automatic follow_path(input request_type r);
      longint      fr [AXES];
      longint      pos [AXES];
      longint      d [AXES];
      longint      mv [AXES];
      longint      seg_len, inc, p, mag;
      logic [69:0] sq, trial, root;
      int          cnt, nxt;
      logic        hit;
      motion_type  m;
      if (r.cmd == CMD_LOAD) begin
         waypoints[r.slot][0] = clamp32(longint'(r.off_x) + origin[0]);
         waypoints[r.slot][1] = clamp32(longint'(r.off_y) + origin[1]);
         waypoints[r.slot][2] = clamp32(longint'(r.off_z) + origin[2]);
         n_loads++;
         return;
      end
      n_ticks++;
      cnt = (count_reg > MAX_WAYPOINTS) ? MAX_WAYPOINTS : int'(count_reg);
      if (cnt == 0) begin
         m = '{0, 0, 0, start_idx, 1'b0, 1'b1};
         expected_motion.push_back(m);
         return;
      end
      if (start_idx >= cnt) start_idx = '0;
      nxt = (start_idx + 1 < cnt) ? start_idx + 1 : 0;
      pos[0] = r.pos_x;
      pos[1] = r.pos_y;
      pos[2] = r.pos_z;
      sq = '0;
      for (int a = 0; a < AXES; a++) begin
         fr[a] = waypoints[start_idx][a];
         d[a] = waypoints[nxt][a] - fr[a];
         mag = (d[a] < 0) ? -d[a] : d[a];
         sq = sq + 70'(mag) * 70'(mag);
      end
      root = '0;
      for (int b = 34; b >= 0; b--) begin
         trial = root | (70'(1) << b);
         if (trial * trial <= sq) root = trial;
      end
      seg_len = longint'(root);
      hit = 1'b0;
      if (seg_len == 0) begin
         for (int a = 0; a < AXES; a++) mv[a] = fr[a];
         hit = 1'b1;
      end else begin
         inc = (longint'(r.dt) * longint'(speed_reg)) / seg_len;
         p = longint'(prog) + inc;
         if (p > longint'(PROG_MAX)) p = longint'(PROG_MAX);
         prog = p[17:0];
         for (int a = 0; a < AXES; a++) mv[a] = fr[a] + ((d[a] * longint'(prog)) >>> 16);
         if (prog >= PROG_ONE) hit = 1'b1;
      end
      if (hit) begin
         prog = '0;
         start_idx = (start_idx + 1 < cnt) ? 4'(start_idx + 1) : 4'd0;
      end
      m.mx = clamp32(mv[0] - pos[0]);
      m.my = clamp32(mv[1] - pos[1]);
      m.mz = clamp32(mv[2] - pos[2]);
      m.seg = start_idx;
      m.hit = hit;
      m.idle = 1'b0;
      expected_motion.push_back(m);
   endtask

   // response checker
   always @(posedge clock) begin
      motion_type w;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_motion.size() == 0) begin
            report("unexpected response, move_x", rsp_if.move_x, 0);
         end else begin
            w = expected_motion.pop_front();
            if (rsp_if.move_x !== w.mx) report("move_x", rsp_if.move_x, w.mx);
            if (rsp_if.move_y !== w.my) report("move_y", rsp_if.move_y, w.my);
            if (rsp_if.move_z !== w.mz) report("move_z", rsp_if.move_z, w.mz);
            if (rsp_if.segment_start !== w.seg)
               report("segment_start", rsp_if.segment_start, w.seg);
            if (rsp_if.reached !== w.hit) report("reached", rsp_if.reached, w.hit);
            if (rsp_if.idle !== w.idle) report("idle", rsp_if.idle, w.idle);
            if (w.hit) n_hits++;
            if (w.idle) n_idle++;
         end
      end
   end

   // response receiver
   initial begin
      int pause;
      forever begin
         pause = busy_sink ? 0 : $urandom_range(0, 8);
         if (pause > 0) begin
            sink_ready <= 1'b0;
            repeat (pause) @(posedge clock);
         end
         sink_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_if.valid && rsp_if.ready));
      end
   end

   task automatic send_request(input request_type r, input int gap);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.cmd        <= r.cmd;
      req_if.slot       <= r.slot;
      req_if.offset_x   <= r.off_x;
      req_if.offset_y   <= r.off_y;
      req_if.offset_z   <= r.off_z;
      req_if.position_x <= r.pos_x;
      req_if.position_y <= r.pos_y;
      req_if.position_z <= r.pos_z;
      req_if.elapsed    <= r.dt;
      do @(posedge clock); while (!req_if.ready);
      follow_path(r);
   endtask

   task automatic wait_idle();
      if (req_if.valid) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      while (expected_motion.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [31:0] value);
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      case (idx)
         CSR_SPEED:    speed_reg = value[23:0];
         CSR_COUNT:    count_reg = value[4:0];
         CSR_ORIGIN_X: origin[0] = longint'(signed'(value));
         CSR_ORIGIN_Y: origin[1] = longint'(signed'(value));
         CSR_ORIGIN_Z: origin[2] = longint'(signed'(value));
         default: ;
      endcase
   endtask

   function automatic logic signed [31:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return 32'sh7FFFFFFF;
         1: return 32'sh80000000;
         2: return $urandom;
         3: return 0;
         default: return $signed($urandom_range(0, 8191)) - 4096;
      endcase
   endfunction

   function automatic request_type load_item(input logic [3:0] slot,
                                              input logic signed [31:0] x,
                                              input logic signed [31:0] y,
                                              input logic signed [31:0] z);
      request_type r;
      r = '{CMD_LOAD, slot, x, y, z, $urandom, $urandom, $urandom, 16'($urandom)};
      return r;
   endfunction

   function automatic request_type tick_item(input logic [15:0] dt);
      request_type r;
      r = '{CMD_TICK, 4'($urandom), $urandom, $urandom, $urandom,
            pick_coord(), pick_coord(), pick_coord(), dt};
      return r;
   endfunction

   function automatic request_type random_item();
      if ($urandom_range(0, 9) < 3)
         return load_item(4'($urandom), pick_coord(), pick_coord(), pick_coord());
      return tick_item(($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4095)));
   endfunction

   task automatic test_empty_loop();
      send_request(tick_item(16'hFFFF), 0);
      send_request(tick_item(16'h0000), $urandom_range(0, 8));
      wait_idle();
   endtask

   task automatic test_extreme_loads();
      write_reg(CSR_ORIGIN_X, 32'h7FFFFFFF);
      write_reg(CSR_ORIGIN_Y, 32'h80000000);
      write_reg(CSR_ORIGIN_Z, 32'h00000100);
      send_request(load_item(4'd0, 32'sh7FFFFFFF, 32'sh80000000, 32'sh0), 0);
      send_request(load_item(4'd1, 32'sh80000000, 32'sh7FFFFFFF, -32'sh100), 1);
      wait_idle();
      write_reg(CSR_ORIGIN_X, 32'h0);
      write_reg(CSR_ORIGIN_Y, 32'h0);
      write_reg(CSR_ORIGIN_Z, 32'h0);
      send_request(load_item(4'd2, 32'sh100, 32'sh100, 32'sh100), 0);
      send_request(load_item(4'd3, 32'sh100, 32'sh100, 32'sh100), 0);
      for (int s = 4; s < MAX_WAYPOINTS; s++)
         send_request(load_item(4'(s), pick_coord(), pick_coord(), pick_coord()),
                      $urandom_range(0, 2));
      wait_idle();
   endtask

   task automatic test_segments();
      write_reg(CSR_SPEED, 32'h00FFFFFF);
      write_reg(CSR_COUNT, 32'd4);
      send_request(tick_item(16'hFFFF), 0);
      send_request(tick_item(16'hFFFF), 0);
      send_request(tick_item(16'h0001), 0);
      send_request(tick_item(16'h0000), 0);
      send_request(tick_item(16'hFFFF), 0);
      wait_idle();
      write_reg(CSR_COUNT, 32'd1);
      send_request(tick_item(16'h1234), 0);
      wait_idle();
      write_reg(CSR_COUNT, 32'd31);
      write_reg(CSR_SPEED, 32'd0);
      send_request(tick_item(16'hFFFF), 0);
      wait_idle();
   endtask

   task automatic test_stalled_output();
      fork
         begin
            hold_off <= 1'b1;
            repeat (1500) @(posedge clock);
            hold_off <= 1'b0;
         end
      join_none
      for (int i = 0; i < 6; i++) send_request(random_item(), 0);
      wait_idle();
   endtask

   task automatic test_random_phases();
      for (int ph = 0; ph < 6; ph++) begin
         wait_idle();
         case (ph)
            0: write_reg(CSR_SPEED, 32'h00FFFFFF);
            1: write_reg(CSR_SPEED, 32'd0);
            default: write_reg(CSR_SPEED, $urandom_range(0, 32'h00FFFFFF));
         endcase
         case (ph)
            0: write_reg(CSR_COUNT, 32'd16);
            1: write_reg(CSR_COUNT, 32'd2);
            2: write_reg(CSR_COUNT, 32'd0);
            3: write_reg(CSR_COUNT, $urandom_range(17, 31));
            default: write_reg(CSR_COUNT, $urandom_range(1, 16));
         endcase
         write_reg(CSR_ORIGIN_X, pick_coord());
         write_reg(CSR_ORIGIN_Y, pick_coord());
         write_reg(CSR_ORIGIN_Z, pick_coord());
         busy_sink <= (ph % 3 == 1);
         for (int i = 0; i < PHASE_LEN; i++)
            send_request(random_item(), (ph % 3 == 1) ? 0 : $urandom_range(0, 8));
      end
      busy_sink <= 1'b0;
      wait_idle();
   endtask

   initial begin
      req_if.valid <= 1'b0;
      req_if.cmd <= CMD_LOAD;
      req_if.slot <= '0;
      req_if.offset_x <= '0;
      req_if.offset_y <= '0;
      req_if.offset_z <= '0;
      req_if.position_x <= '0;
      req_if.position_y <= '0;
      req_if.position_z <= '0;
      req_if.elapsed <= '0;
      csr_if.valid <= 1'b0;
      csr_if.index <= CSR_SPEED;
      csr_if.data <= '0;
      speed_reg = '0;
      count_reg = '0;
      start_idx = '0;
      prog = '0;
      for (int a = 0; a < AXES; a++) origin[a] = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_loop();
      test_extreme_loads();
      test_segments();
      test_stalled_output();
      test_random_phases();

      $display("covered %0d ticks and %0d loads: %0d segments reached, %0d idle responses",
               n_ticks, n_loads, n_hits, n_idle);
      $display("register settings swept speed, count and origin extremes, with output stall");
      if (errors == 0) begin
         $display("waypoint_path_follower regression: pass");
      end else begin
         $display("waypoint_path_follower regression: fail");
      end
      $finish;
   end

endmodule
